// File: hw/rtl/point_cloud_max_height_grid_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point cloud max height grid
// Concurrent assertion wrappers, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_MAX_HEIGHT_GRID_TOP_MACROS_SVH
`define POINT_CLOUD_MAX_HEIGHT_GRID_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PCMH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCMH_ASSERT(lbl, clk, rst, prop, msg)
`define PCMH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/pcmh_pkg.sv
// ----------------------------------------------------------------------------
// pcmh_pkg
// Shared types and constants of the max height grid.
// ----------------------------------------------------------------------------
package pcmh_pkg;

   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned VALUE_W   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X     = 4'd0,
      CSR_ORIGIN_Y     = 4'd1,
      CSR_CELL_WIDTH   = 4'd2,
      CSR_CELL_DEPTH   = 4'd3,
      CSR_TOP_HEIGHT   = 4'd4,
      CSR_LEVEL_COUNT  = 4'd5,
      CSR_COLUMNS_USED = 4'd6,
      CSR_ROWS_USED    = 4'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cell_value;
      logic               in_range;
      logic               raised;
   } rsp_payload_type;

endpackage

// File: hw/rtl/pcmh_channel_if.sv
// ----------------------------------------------------------------------------
// pcmh channel interfaces
// Point request, cell result and register write channels.
// ----------------------------------------------------------------------------
interface pcmh_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] raw_x;
   logic signed [31:0] raw_y;
   logic signed [31:0] raw_z;
   logic [7:0]         read_column;
   logic [7:0]         read_row;
   modport source (output valid, mode, raw_x, raw_y, raw_z, read_column, read_row,
                   input ready);
   modport sink   (input valid, mode, raw_x, raw_y, raw_z, read_column, read_row,
                   output ready);
endinterface

interface pcmh_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_value;
   logic        in_range;
   logic        raised;
   modport source (output valid, cell_value, in_range, raised, input ready);
   modport sink   (input valid, cell_value, in_range, raised, output ready);
endinterface

interface pcmh_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/point_cloud_max_height_grid_top.sv
// ----------------------------------------------------------------------------
// point_cloud_max_height_grid_top
// Max height rasterization of lidar points into a grid of height levels.
//
//   channel  dir  transaction
//   req_ch   in   point to accumulate, or cell to read
//   rsp_ch   out  cell value, in_range, raised
//   csr_ch   in   register write (index, data)
//
// A point goes through offset, multiply, the bin dividers (level divider
// runs alongside), memory read, write back; a read goes through memory
// read and result. One transaction in flight; the result register
// lets the next request enter while a result waits.
// After reset the grid is zeroed, all MAX_COLS*MAX_ROWS entries (65536 by
// default), with req_ch.ready low; register writes are taken at all times.
// ----------------------------------------------------------------------------
`include "point_cloud_max_height_grid_top_macros.svh"

module point_cloud_max_height_grid_top #(
   parameter int unsigned MAX_COLS = 256,
   parameter int unsigned MAX_ROWS = 256
) (
   input  logic       clock,
   input  logic       reset,
   pcmh_req_if.sink   req_ch,
   pcmh_rsp_if.source rsp_ch,
   pcmh_csr_if.sink   csr_ch
);
   import pcmh_pkg::*;

   localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
   localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
   localparam int unsigned RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [15:0]        cell_width_ff, cell_depth_ff, level_count_ff;
   logic [30:0]        top_height_ff;
   logic [8:0]         columns_used_ff, rows_used_ff;

   state_type          state_ff, state_in;
   logic               mode_ff;
   logic [32:0]        off_x_ff, off_y_ff;
   logic signed [31:0] z_ff;
   logic [7:0]         rd_col_ff, rd_row_ff;
   logic [46:0]        prod_ff;
   logic               sat_ff;
   logic               ok_ff;
   logic [15:0]        lvl_ff;
   logic [AW-1:0]      addr_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic [31:0]        lim_x, lim_y;
   logic [15:0]        den_x, den_y;
   logic [30:0]        top_t;
   logic [31:0]        den_l;
   logic [48:0]        lvl_num;
   logic               div_start;
   logic               done_x, done_y, done_l;
   logic [31:0]        q_x, q_y;
   logic [15:0]        q_l;
   logic               z_pos;
   logic               accept;
   logic               slot_free;
   logic               mem_we;
   logic [15:0]        mem_rdata;
   logic               clear_busy;
   logic               bin_ok, rd_ok;
   logic               raise;

   // register file
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         cell_width_ff   <= 16'd1;
         cell_depth_ff   <= 16'd1;
         top_height_ff   <= 31'd1;
         level_count_ff  <= 16'd1;
         columns_used_ff <= 9'd256;
         rows_used_ff    <= 9'd256;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_ORIGIN_X:     origin_x_ff     <= csr_ch.data;
            CSR_ORIGIN_Y:     origin_y_ff     <= csr_ch.data;
            CSR_CELL_WIDTH:   cell_width_ff   <= csr_ch.data[15:0];
            CSR_CELL_DEPTH:   cell_depth_ff   <= csr_ch.data[15:0];
            CSR_TOP_HEIGHT:   top_height_ff   <= csr_ch.data[30:0];
            CSR_LEVEL_COUNT:  level_count_ff  <= csr_ch.data[15:0];
            CSR_COLUMNS_USED: columns_used_ff <= csr_ch.data[8:0];
            CSR_ROWS_USED:    rows_used_ff    <= csr_ch.data[8:0];
            default: ;
         endcase
      end
   end

   assign lim_x = (32'(columns_used_ff) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
                                                         : 32'(columns_used_ff);
   assign lim_y = (32'(rows_used_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                      : 32'(rows_used_ff);
   assign den_x = (cell_width_ff == '0) ? 16'd1 : cell_width_ff;
   assign den_y = (cell_depth_ff == '0) ? 16'd1 : cell_depth_ff;
   assign top_t = (top_height_ff == '0) ? 31'd1 : top_height_ff;
   assign den_l = {top_t, 1'b0};
   assign lvl_num = 49'({prod_ff, 1'b0}) + 49'(top_t);

   // dividers
   assign div_start = (state_ff == ST_MUL);

   pcmh_divider #(.NW(33), .QW(32), .DW(16)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .num(off_x_ff), .den(den_x), .done(done_x), .quot(q_x)
   );

   pcmh_divider #(.NW(33), .QW(32), .DW(16)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .num(off_y_ff), .den(den_y), .done(done_y), .quot(q_y)
   );

   pcmh_divider #(.NW(49), .QW(16), .DW(32)) u_div_l (
      .clock(clock), .reset(reset), .start(div_start),
      .num(lvl_num), .den(den_l), .done(done_l), .quot(q_l)
   );

   // grid store
   assign raise  = ok_ff && (lvl_ff > mem_rdata);
   assign mem_we = (state_ff == ST_WRITE) && slot_free && raise;

   pcmh_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_grid (
      .clock(clock), .reset(reset),
      .we(mem_we), .waddr(addr_ff), .wdata(lvl_ff),
      .raddr(addr_ff), .rdata(mem_rdata), .clear_busy(clear_busy)
   );

   // control
   assign req_ch.ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign z_pos        = !z_ff[31] && (z_ff != '0);
   assign bin_ok       = !off_x_ff[32] && !off_y_ff[32] && (q_x < lim_x) && (q_y < lim_y);
   assign rd_ok        = (32'(rd_col_ff) < lim_x) && (32'(rd_row_ff) < lim_y);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = req_ch.mode ? ST_READ : ST_MUL;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   if (done_x && done_y && done_l) state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WRITE && slot_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)                  rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_ch.mode;
         off_x_ff  <= 33'(req_ch.raw_x) - 33'(origin_x_ff);
         off_y_ff  <= 33'(req_ch.raw_y) - 33'(origin_y_ff);
         z_ff      <= req_ch.raw_z;
         rd_col_ff <= req_ch.read_column;
         rd_row_ff <= req_ch.read_row;
      end
      if (state_ff == ST_MUL) begin
         sat_ff <= lvl_num >= {1'b0, den_l, 16'd0};
      end
      if (state_ff == ST_IDLE) begin
         prod_ff <= 47'(req_ch.raw_z[30:0]) * 47'(level_count_ff);
      end
      if (state_ff == ST_IDLE && accept && req_ch.mode) begin
         ok_ff  <= 1'b0;
         lvl_ff <= '0;
      end
      if (state_ff == ST_READ && mode_ff) begin
         ok_ff <= rd_ok;
      end
      if (state_ff == ST_DIV) begin
         ok_ff   <= bin_ok;
         addr_ff <= AW'(AW'(q_y[RW-1:0]) * AW'(MAX_COLS) + AW'(q_x[CW-1:0]));
         lvl_ff  <= !z_pos ? 16'd0 : (sat_ff ? 16'hFFFF : q_l);
      end
      if (accept && req_ch.mode) begin
         addr_ff <= AW'(AW'(RW'(req_ch.read_row)) * AW'(MAX_COLS)
                        + AW'(CW'(req_ch.read_column)));
      end
      if (state_ff == ST_WRITE && slot_free) begin
         rsp_ff.in_range   <= ok_ff;
         rsp_ff.raised     <= !mode_ff && raise;
         rsp_ff.cell_value <= !ok_ff ? 16'd0 : (raise && !mode_ff ? lvl_ff : mem_rdata);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_value = rsp_ff.cell_value;
   assign rsp_ch.in_range   = rsp_ff.in_range;
   assign rsp_ch.raised     = rsp_ff.raised;

   `PCMH_ASSERT_ALWAYS(a_no_req_in_clear, clock,
      clear_busy |-> !req_ch.ready, "request taken during clear")
   `PCMH_ASSERT(a_we_in_write, clock, reset,
      mem_we |-> (state_ff == ST_WRITE), "grid write outside write state")
   `PCMH_ASSERT(a_rsp_from_write, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE), "result without write state")
   `PCMH_ASSERT(a_accept_leaves_idle, clock, reset,
      accept |=> (state_ff != ST_IDLE), "accepted request did not start")
endmodule

// File: hw/rtl/pcmh_divider.sv
// ----------------------------------------------------------------------------
// pcmh_divider
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees num >> QW is below den.
// ----------------------------------------------------------------------------
module pcmh_divider #(
   parameter int unsigned NW = 33,
   parameter int unsigned QW = 32,
   parameter int unsigned DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QW-1:0] quot
);
   localparam int unsigned HW = NW - QW;
   localparam int unsigned CNW = $clog2(QW + 1);

   logic [DW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic [DW-1:0]  den_ff;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [HW-1:0]  hi;
   logic [DW:0]    trial;
   logic           ge;

   assign hi    = num[NW-1:QW];
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = DW'(hi);
         quo_in  = num[QW-1:0];
         cnt_in  = CNW'(QW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

// File: hw/rtl/pcmh_grid_mem.sv
// ----------------------------------------------------------------------------
// pcmh_grid_mem
// Height grid store: one write port, one registered read port, and a
// zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module pcmh_grid_mem #(
   parameter int unsigned DEPTH = 65536,
   parameter int unsigned AW    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [15:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [15:0]   rdata,
   output logic          clear_busy
);
   logic [15:0]   mem [DEPTH];
   logic [15:0]   rdata_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata      = rdata_ff;
   assign clear_busy = clr_busy_ff;
endmodule
